// ===== src/spps_pkg.sv =====
// ----------------------------------------------------------------------------
// spps_pkg
// Shared types, constants and tables for the sphere preview pixel shader.
// ----------------------------------------------------------------------------
package spps_pkg;

    localparam int PREVIEW_SIZE_DEF = 96;
    localparam int PIX_W            = 7;
    localparam int CFG_W            = 9;
    localparam int IDX_W            = 3;
    localparam int CH_W             = 8;

    typedef enum logic [IDX_W-1:0] {
        CFG_ALBEDO_RED   = 3'd0,
        CFG_ALBEDO_GREEN = 3'd1,
        CFG_ALBEDO_BLUE  = 3'd2,
        CFG_METALLIC     = 3'd3,
        CFG_ROUGHNESS    = 3'd4,
        CFG_ROTATION     = 3'd5
    } t_cfg_idx;

    localparam logic [CH_W-1:0] BG_RED   = 8'd24;
    localparam logic [CH_W-1:0] BG_GREEN = 8'd24;
    localparam logic [CH_W-1:0] BG_BLUE  = 8'd28;

    localparam logic signed [15:0] LIGHT_X = 16'sd5771;
    localparam logic signed [15:0] LIGHT_Y = 16'sd12366;
    localparam logic signed [15:0] LIGHT_Z = 16'sd9068;
    localparam logic signed [15:0] HALF_X  = 16'sd3274;
    localparam logic signed [15:0] HALF_Y  = 16'sd7015;
    localparam logic signed [15:0] HALF_Z  = 16'sd14440;

    localparam logic [16:0] ROOT2_Q16 [8] = '{
        17'd92682, 17'd77936, 17'd71468, 17'd68438,
        17'd66971, 17'd66250, 17'd65892, 17'd65714
    };
    localparam logic [15:0] LN2_Q16 = 16'd45426;

    localparam int TRIG_N = 46;
    typedef logic [TRIG_N-1:0][14:0] t_trig_tab;

    localparam longint unsigned Q30_ONE = 64'd1 << 30;
    localparam longint unsigned PI_Q30  = 64'd3373259426;

    function automatic logic [14:0] to_q14(input longint unsigned v30);
        longint unsigned r;
        r = (v30 + (64'd1 << 15)) >> 16;
        if (r > 64'd16384) begin
            r = 64'd16384;
        end
        return r[14:0];
    endfunction

    // Taylor series on 0..45 degrees, evaluated at elaboration
    function automatic t_trig_tab trig_table(input logic want_cos);
        t_trig_tab       tab;
        longint unsigned r;
        longint unsigned r2;
        longint unsigned t;
        tab = '0;
        for (int e = 0; e < TRIG_N; e++) begin
            r  = longint'(e) * PI_Q30 / 180;
            r2 = (r * r) >> 30;
            if (want_cos) begin
                t = Q30_ONE - r2 / 56;
                t = Q30_ONE - ((r2 * t) >> 30) / 30;
                t = Q30_ONE - ((r2 * t) >> 30) / 12;
                t = Q30_ONE - ((r2 * t) >> 30) / 2;
                tab[e] = to_q14(t);
            end else begin
                t = Q30_ONE - r2 / 42;
                t = Q30_ONE - ((r2 * t) >> 30) / 20;
                t = Q30_ONE - ((r2 * t) >> 30) / 6;
                tab[e] = to_q14((r * t) >> 30);
            end
        end
        return tab;
    endfunction

    localparam t_trig_tab SIN_TAB = trig_table(1'b0);
    localparam t_trig_tab COS_TAB = trig_table(1'b1);

    typedef struct packed {
        logic [CFG_W-1:0]  albedo_red;
        logic [CFG_W-1:0]  albedo_green;
        logic [CFG_W-1:0]  albedo_blue;
        logic [CFG_W-1:0]  metallic;
        logic [14:0]       pq8;
        logic signed [15:0] sin_q14;
        logic signed [15:0] cos_q14;
    } t_cfg;

    typedef struct packed {
        logic        in_disc;
        logic [14:0] diffuse;
    } t_side;

endpackage

// ===== src/spps_cfg.sv =====
// ----------------------------------------------------------------------------
// spps_cfg
// Configuration registers and the values derived from them.
// ----------------------------------------------------------------------------
module spps_cfg
    import spps_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    output t_cfg             o_cfg
);

    logic [CFG_W-1:0] r_alb_r, r_alb_g, r_alb_b, r_metal, r_rough, r_rot;
    logic signed [15:0] r_sin, r_cos;
    logic [14:0]        r_pq8;

    logic signed [15:0] n_sin, n_cos;
    logic [14:0]        n_pq8;
    logic [8:0]         d;
    logic [6:0]         e;
    logic [6:0]         e_m;
    logic [1:0]         q;
    logic signed [15:0] a, b;
    logic [15:0]        rprod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alb_r <= 9'd256;
            r_alb_g <= 9'd256;
            r_alb_b <= 9'd256;
            r_metal <= 9'd0;
            r_rough <= 9'd128;
            r_rot   <= 9'd0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ALBEDO_RED:   r_alb_r <= i_cfg_data;
                CFG_ALBEDO_GREEN: r_alb_g <= i_cfg_data;
                CFG_ALBEDO_BLUE:  r_alb_b <= i_cfg_data;
                CFG_METALLIC:     r_metal <= i_cfg_data;
                CFG_ROUGHNESS:    r_rough <= i_cfg_data;
                CFG_ROTATION:     r_rot   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        d = (r_rot >= 9'd360) ? (r_rot - 9'd360) : r_rot;
        if (d < 9'd90) begin
            q = 2'd0;
            e = d[6:0];
        end else if (d < 9'd180) begin
            q = 2'd1;
            e = 7'(d - 9'd90);
        end else if (d < 9'd270) begin
            q = 2'd2;
            e = 7'(d - 9'd180);
        end else begin
            q = 2'd3;
            e = 7'(d - 9'd270);
        end
        e_m = 7'd90 - e;
        if (e <= 7'd45) begin
            a = $signed({1'b0, SIN_TAB[e[5:0]]});
            b = $signed({1'b0, COS_TAB[e[5:0]]});
        end else begin
            a = $signed({1'b0, COS_TAB[e_m[5:0]]});
            b = $signed({1'b0, SIN_TAB[e_m[5:0]]});
        end
        case (q)
            2'd0: begin n_sin = a;  n_cos = b;  end
            2'd1: begin n_sin = b;  n_cos = -a; end
            2'd2: begin n_sin = -a; n_cos = -b; end
            default: begin n_sin = -b; n_cos = a; end
        endcase
        rprod = 16'(r_rough) * 16'd96;
        n_pq8 = (rprod > 16'd25600) ? 15'd1024 : 15'(16'd26624 - rprod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sin <= 16'sd0;
            r_cos <= 16'sd16384;
            r_pq8 <= 15'd14336;
        end else begin
            r_sin <= n_sin;
            r_cos <= n_cos;
            r_pq8 <= n_pq8;
        end
    end

    assign o_cfg.albedo_red   = r_alb_r;
    assign o_cfg.albedo_green = r_alb_g;
    assign o_cfg.albedo_blue  = r_alb_b;
    assign o_cfg.metallic     = r_metal;
    assign o_cfg.pq8          = r_pq8;
    assign o_cfg.sin_q14      = r_sin;
    assign o_cfg.cos_q14      = r_cos;

endmodule

// ===== src/spps_geom.sv =====
// ----------------------------------------------------------------------------
// spps_geom
// Pixel to disc coordinates, sphere height, rotation and the two dot products.
// ----------------------------------------------------------------------------
module spps_geom
    import spps_pkg::*;
#(
    parameter int PREVIEW_SIZE = PREVIEW_SIZE_DEF
)(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [PIX_W-1:0] i_pixel_x,
    input  logic [PIX_W-1:0] i_pixel_y,
    input  t_cfg             i_cfg,
    output logic             o_valid,
    output t_side            o_side,
    output logic [14:0]      o_ndh
);

    localparam int SPAN    = PREVIEW_SIZE - 1;
    localparam int MAG_MAX = (SPAN > 254) ? SPAN : 254;
    localparam int NMAG_W  = $clog2(MAG_MAX + 1);
    localparam int NN_W    = NMAG_W + 2;
    localparam int NW      = NMAG_W + 15;
    localparam longint unsigned RECIP = (64'd1 << 32) / SPAN;
    localparam int RW      = $clog2(RECIP + 1);
    localparam int PW      = NW + RW;
    localparam int SW      = NW + NMAG_W;
    localparam int LW      = 2 * NW + 2;
    localparam int SQ_ST   = 4;
    localparam int SQ_STEP = 4;
    localparam int SQ_IT   = 15;

    function automatic logic [14:0] dot_q14(input logic signed [50:0] dv);
        logic [22:0] r;
        r = 23'(dv >>> 28);
        if (dv <= 51'sd0) begin
            return 15'd0;
        end
        return (r > 23'd16384) ? 15'd16384 : r[14:0];
    endfunction

    // stage 1: |2p - span| * 2^14 + span/2
    logic signed [NN_W-1:0] nx, ny;
    logic [NMAG_W-1:0]      mx, my;
    logic [NW-1:0]          r_s1_num_x, r_s1_num_y;
    logic                   r_s1_neg_x, r_s1_neg_y, r_s1_vld;

    always_comb begin
        nx = $signed({{(NN_W-PIX_W-1){1'b0}}, i_pixel_x, 1'b0}) - NN_W'(SPAN);
        ny = $signed({{(NN_W-PIX_W-1){1'b0}}, i_pixel_y, 1'b0}) - NN_W'(SPAN);
        mx = NMAG_W'(nx[NN_W-1] ? -nx : nx);
        my = NMAG_W'(ny[NN_W-1] ? -ny : ny);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_num_x <= NW'({mx, 14'd0}) + NW'(SPAN / 2);
            r_s1_num_y <= NW'({my, 14'd0}) + NW'(SPAN / 2);
            r_s1_neg_x <= nx[NN_W-1];
            r_s1_neg_y <= ny[NN_W-1];
        end
    end

    // stage 2: quotient estimate by reciprocal
    logic [PW-1:0] px, py;
    logic [NW-1:0] r_s2_q_x, r_s2_q_y, r_s2_num_x, r_s2_num_y;
    logic          r_s2_neg_x, r_s2_neg_y, r_s2_vld;

    assign px = PW'(r_s1_num_x) * PW'(RECIP);
    assign py = PW'(r_s1_num_y) * PW'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_q_x   <= NW'(px >> 32);
            r_s2_q_y   <= NW'(py >> 32);
            r_s2_num_x <= r_s1_num_x;
            r_s2_num_y <= r_s1_num_y;
            r_s2_neg_x <= r_s1_neg_x;
            r_s2_neg_y <= r_s1_neg_y;
        end
    end

    // stage 3: one correction step, apply sign
    logic [SW-1:0]        rem_x, rem_y;
    logic [NW-1:0]        qx, qy;
    logic signed [NW:0]   r_s3_u, r_s3_v;
    logic                 r_s3_vld;

    always_comb begin
        rem_x = SW'(r_s2_num_x) - SW'(r_s2_q_x) * SW'(SPAN);
        rem_y = SW'(r_s2_num_y) - SW'(r_s2_q_y) * SW'(SPAN);
        qx    = (rem_x >= SW'(SPAN)) ? r_s2_q_x + 1'b1 : r_s2_q_x;
        qy    = (rem_y >= SW'(SPAN)) ? r_s2_q_y + 1'b1 : r_s2_q_y;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3_u <= r_s2_neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
            r_s3_v <= r_s2_neg_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
        end
    end

    // stage 4: squares
    logic signed [LW-1:0] r_s4_su, r_s4_sv;
    logic signed [15:0]   r_s4_u, r_s4_v;
    logic                 r_s4_vld;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s4_su <= LW'(r_s3_u) * LW'(r_s3_u);
            r_s4_sv <= LW'(r_s3_v) * LW'(r_s3_v);
            r_s4_u  <= r_s3_u[15:0];
            r_s4_v  <= r_s3_v[15:0];
        end
    end

    // stage 5: disc test, radicand
    logic [LW:0] len;
    assign len = {1'b0, r_s4_su} + {1'b0, r_s4_sv};

    logic [29:0]        r_sq_a   [0:SQ_ST];
    logic [29:0]        r_sq_res [0:SQ_ST];
    logic signed [15:0] r_sq_u   [0:SQ_ST];
    logic signed [15:0] r_sq_v   [0:SQ_ST];
    logic               r_sq_in  [0:SQ_ST];
    logic               r_sq_vld [0:SQ_ST];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_a[0]   <= {1'b0, 29'h1000_0000 - len[28:0]};
            r_sq_res[0] <= 30'd0;
            r_sq_u[0]   <= r_s4_u;
            r_sq_v[0]   <= r_s4_v;
            r_sq_in[0]  <= (len <= (LW+1)'(30'h1000_0000));
        end
    end

    // integer square root, up to four steps per stage
    for (genvar s = 0; s < SQ_ST; s++) begin : g_sqrt
        logic [29:0] n_a, n_res;
        always_comb begin
            logic [29:0] bv;
            bv    = '0;
            n_a   = r_sq_a[s];
            n_res = r_sq_res[s];
            for (int j = 0; j < SQ_STEP; j++) begin
                if (s * SQ_STEP + j < SQ_IT) begin
                    bv = 30'd1 << (28 - 2 * (s * SQ_STEP + j));
                    if (n_a >= n_res + bv) begin
                        n_a   = n_a - (n_res + bv);
                        n_res = (n_res >> 1) + bv;
                    end else begin
                        n_res = n_res >> 1;
                    end
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_sq_vld[s+1] <= r_sq_vld[s];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq_a[s+1]   <= n_a;
                r_sq_res[s+1] <= n_res;
                r_sq_u[s+1]   <= r_sq_u[s];
                r_sq_v[s+1]   <= r_sq_v[s];
                r_sq_in[s+1]  <= r_sq_in[s];
            end
        end
    end

    // rotation about Y
    logic signed [15:0] zs;
    logic signed [31:0] r_s6_uc, r_s6_zs, r_s6_us, r_s6_zc;
    logic signed [15:0] r_s6_v;
    logic               r_s6_in, r_s6_vld;

    assign zs = $signed({1'b0, r_sq_res[SQ_ST][14:0]});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s6_uc <= r_sq_u[SQ_ST] * i_cfg.cos_q14;
            r_s6_zs <= zs * i_cfg.sin_q14;
            r_s6_us <= r_sq_u[SQ_ST] * i_cfg.sin_q14;
            r_s6_zc <= zs * i_cfg.cos_q14;
            r_s6_v  <= r_sq_v[SQ_ST];
            r_s6_in <= r_sq_in[SQ_ST];
        end
    end

    logic signed [32:0] r_s7_nx, r_s7_ny, r_s7_nz;
    logic               r_s7_in, r_s7_vld;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s7_nx <= 33'(r_s6_uc) - 33'(r_s6_zs);
            r_s7_nz <= 33'(r_s6_us) + 33'(r_s6_zc);
            r_s7_ny <= 33'(r_s6_v) <<< 14;
            r_s7_in <= r_s6_in;
        end
    end

    // dot products with L and H
    logic signed [48:0] r_s8_lx, r_s8_ly, r_s8_lz, r_s8_hx, r_s8_hy, r_s8_hz;
    logic               r_s8_in, r_s8_vld;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s8_lx <= 49'(r_s7_nx) * 49'(LIGHT_X);
            r_s8_ly <= 49'(r_s7_ny) * 49'(LIGHT_Y);
            r_s8_lz <= 49'(r_s7_nz) * 49'(LIGHT_Z);
            r_s8_hx <= 49'(r_s7_nx) * 49'(HALF_X);
            r_s8_hy <= 49'(r_s7_ny) * 49'(HALF_Y);
            r_s8_hz <= 49'(r_s7_nz) * 49'(HALF_Z);
            r_s8_in <= r_s7_in;
        end
    end

    logic [14:0] ndl, ndh;
    logic [16:0] ndl3;
    t_side       r_s9_side;
    logic [14:0] r_s9_ndh;
    logic        r_s9_vld;

    always_comb begin
        ndl  = dot_q14(51'(r_s8_lx) + 51'(r_s8_ly) + 51'(r_s8_lz));
        ndh  = dot_q14(51'(r_s8_hx) + 51'(r_s8_hy) + 51'(r_s8_hz));
        ndl3 = 17'(ndl) * 17'd3;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s9_side.in_disc <= r_s8_in;
            r_s9_side.diffuse <= 15'd4096 + 15'(ndl3 >> 2);
            r_s9_ndh          <= ndh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_s3_vld    <= 1'b0;
            r_s4_vld    <= 1'b0;
            r_sq_vld[0] <= 1'b0;
            r_s6_vld    <= 1'b0;
            r_s7_vld    <= 1'b0;
            r_s8_vld    <= 1'b0;
            r_s9_vld    <= 1'b0;
        end else if (i_en) begin
            r_s1_vld    <= i_valid;
            r_s2_vld    <= r_s1_vld;
            r_s3_vld    <= r_s2_vld;
            r_s4_vld    <= r_s3_vld;
            r_sq_vld[0] <= r_s4_vld;
            r_s6_vld    <= r_sq_vld[SQ_ST];
            r_s7_vld    <= r_s6_vld;
            r_s8_vld    <= r_s7_vld;
            r_s9_vld    <= r_s8_vld;
        end
    end

    assign o_valid = r_s9_vld;
    assign o_side  = r_s9_side;
    assign o_ndh   = r_s9_ndh;

endmodule

// ===== src/spps_pow.sv =====
// ----------------------------------------------------------------------------
// spps_pow
// Specular power: log2 by repeated squaring, scale, exp2 by roots of two.
// ----------------------------------------------------------------------------
module spps_pow
    import spps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [14:0] i_x,
    input  t_side       i_side,
    input  t_cfg        i_cfg,
    output logic        o_valid,
    output logic [15:0] o_pow,
    output t_side       o_side
);

    localparam int SQ_N   = 16;
    localparam int ROOT_N = 8;

    // leading one and Q15 mantissa
    logic [3:0]  msb;
    always_comb begin
        msb = 4'd0;
        for (int i = 1; i < 15; i++) begin
            if (i_x[i]) begin
                msb = 4'(i);
            end
        end
    end

    logic [15:0] r_mant [0:SQ_N];
    logic [15:0] r_f    [0:SQ_N];
    logic [3:0]  r_m    [0:SQ_N];
    logic        r_zero [0:SQ_N];
    t_side       r_side [0:SQ_N];
    logic        r_vld  [0:SQ_N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mant[0] <= {1'b0, i_x} << (4'd15 - msb);
            r_f[0]    <= 16'd0;
            r_m[0]    <= msb;
            r_zero[0] <= (i_x == 15'd0);
            r_side[0] <= i_side;
        end
    end

    for (genvar s = 0; s < SQ_N; s++) begin : g_sq
        logic [31:0] sq;
        assign sq = 32'(r_mant[s]) * 32'(r_mant[s]);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= r_vld[s];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_mant[s+1] <= sq[31] ? sq[31:16] : sq[30:15];
                r_f[s+1]    <= {r_f[s][14:0], sq[31]};
                r_m[s+1]    <= r_m[s];
                r_zero[s+1] <= r_zero[s];
                r_side[s+1] <= r_side[s];
            end
        end
    end

    // scale -log2 by the exponent
    logic [19:0] nl;
    logic [34:0] tp;
    logic [26:0] r_t;
    logic        r_t_zero, r_t_vld;
    t_side       r_t_side;

    assign nl = {4'(4'd14 - r_m[SQ_N]), 16'd0} - 20'(r_f[SQ_N]);
    assign tp = 35'(nl) * 35'(i_cfg.pq8);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t      <= tp[34:8];
            r_t_zero <= r_zero[SQ_N];
            r_t_side <= r_side[SQ_N];
        end
    end

    // 2^-t from the fraction bits
    logic [17:0] r_acc  [0:ROOT_N];
    logic [16:0] r_h    [0:ROOT_N];
    logic [10:0] r_k    [0:ROOT_N];
    logic        r_zr   [0:ROOT_N];
    t_side       r_rs   [0:ROOT_N];
    logic        r_rvld [0:ROOT_N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc[0] <= (r_t[15:0] == 16'd0) ? 18'd131072 : 18'd65536;
            r_h[0]   <= 17'h10000 - 17'(r_t[15:0]);
            r_k[0]   <= r_t[26:16];
            r_zr[0]  <= r_t_zero;
            r_rs[0]  <= r_t_side;
        end
    end

    for (genvar i = 0; i < ROOT_N; i++) begin : g_root
        logic [34:0] pr;
        assign pr = 35'(r_acc[i]) * 35'(ROOT2_Q16[i]);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rvld[i+1] <= 1'b0;
            end else if (i_en) begin
                r_rvld[i+1] <= r_rvld[i];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[i+1] <= r_h[i][15-i] ? pr[33:16] : r_acc[i];
                r_h[i+1]   <= r_h[i];
                r_k[i+1]   <= r_k[i];
                r_zr[i+1]  <= r_zr[i];
                r_rs[i+1]  <= r_rs[i];
            end
        end
    end

    // linear term for the low byte
    logic [25:0] r_p_prod;
    logic [17:0] r_p_acc;
    logic [10:0] r_p_k;
    logic        r_p_zero, r_p_vld;
    t_side       r_p_side;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_prod <= 26'(r_acc[ROOT_N]) * 26'(r_h[ROOT_N][7:0]);
            r_p_acc  <= r_acc[ROOT_N];
            r_p_k    <= r_k[ROOT_N];
            r_p_zero <= r_zr[ROOT_N];
            r_p_side <= r_rs[ROOT_N];
        end
    end

    logic [41:0] lp;
    logic [9:0]  r_l_ln;
    logic [17:0] r_l_acc;
    logic [10:0] r_l_k;
    logic        r_l_zero, r_l_vld;
    t_side       r_l_side;

    assign lp = 42'(r_p_prod) * 42'(LN2_Q16);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_l_ln   <= lp[41:32];
            r_l_acc  <= r_p_acc;
            r_l_k    <= r_p_k;
            r_l_zero <= r_p_zero;
            r_l_side <= r_p_side;
        end
    end

    logic [18:0] sum;
    logic [11:0] sh;
    logic [15:0] r_o_pow;
    logic        r_o_vld;
    t_side       r_o_side;

    assign sum = 19'(r_l_acc) + 19'(r_l_ln);
    assign sh  = 12'(r_l_k) + 12'd3;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o_pow  <= (r_l_zero || sh >= 12'd32) ? 16'd0 : 16'(sum >> sh[4:0]);
            r_o_side <= r_l_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0]  <= 1'b0;
            r_t_vld   <= 1'b0;
            r_rvld[0] <= 1'b0;
            r_p_vld   <= 1'b0;
            r_l_vld   <= 1'b0;
            r_o_vld   <= 1'b0;
        end else if (i_en) begin
            r_vld[0]  <= i_valid;
            r_t_vld   <= r_vld[SQ_N];
            r_rvld[0] <= r_t_vld;
            r_p_vld   <= r_rvld[ROOT_N];
            r_l_vld   <= r_p_vld;
            r_o_vld   <= r_l_vld;
        end
    end

    assign o_valid = r_o_vld;
    assign o_pow   = r_o_pow;
    assign o_side  = r_o_side;

endmodule

// ===== src/spps_mix.sv =====
// ----------------------------------------------------------------------------
// spps_mix
// Albedo times diffuse plus weighted specular, scaled to 8-bit channels;
// pixels outside the disc get the background colour.
module spps_mix
    import spps_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [15:0]     i_pow,
    input  t_side           i_side,
    input  t_cfg            i_cfg,
    output logic            o_valid,
    output logic [CH_W-1:0] o_red,
    output logic [CH_W-1:0] o_green,
    output logic [CH_W-1:0] o_blue,
    output logic            o_inside
);

    function automatic logic [CH_W-1:0] chan(input logic [23:0] ad,
                                            input logic [24:0] sp);
        logic [25:0] s;
        logic [33:0] m;
        logic [11:0] v;
        s = 26'(ad) + 26'(sp);
        m = {s, 8'd0} - 34'(s);
        v = m[33:22];
        return (v > 12'd255) ? 8'd255 : v[7:0];
    endfunction

    logic [24:0] r_spec;
    logic [23:0] r_ar, r_ag, r_ab;
    logic        r_in, r_vld;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_spec <= 25'(i_pow) * 25'(i_cfg.metallic);
            r_ar   <= 24'(i_cfg.albedo_red) * 24'(i_side.diffuse);
            r_ag   <= 24'(i_cfg.albedo_green) * 24'(i_side.diffuse);
            r_ab   <= 24'(i_cfg.albedo_blue) * 24'(i_side.diffuse);
            r_in   <= i_side.in_disc;
        end
    end

    logic [CH_W-1:0] r_red, r_green, r_blue;
    logic            r_o_in, r_o_vld;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_red   <= r_in ? chan(r_ar, r_spec) : BG_RED;
            r_green <= r_in ? chan(r_ag, r_spec) : BG_GREEN;
            r_blue  <= r_in ? chan(r_ab, r_spec) : BG_BLUE;
            r_o_in  <= r_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (i_en) begin
            r_vld   <= i_valid;
            r_o_vld <= r_vld;
        end
    end

    assign o_valid  = r_o_vld;
    assign o_red    = r_red;
    assign o_green  = r_green;
    assign o_blue   = r_blue;
    assign o_inside = r_o_in;

endmodule

// ===== src/sphere_preview_pixel_shader_core.sv =====
// ----------------------------------------------------------------------------
// sphere_preview_pixel_shader_core
// Shades one pixel of a lit sphere preview per clock while not stalled.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  in      | i_in_valid o_in_ready i_pixel_x/y        | pixel coordinate in
//  out     | o_out_valid i_out_ready o_red/green/blue | shaded pixel out
//          | o_inside_sphere                          |
//  cfg     | i_cfg_valid o_cfg_ready i_cfg_index/data | register write
//
//  One pixel per clock while the output is not stalled; the pipeline holds
//  the 16 squaring and 8 root stages of the power unit and the 4 square root
//  stages. Synchronous active-low reset clears all valid bits and loads the
//  register defaults. A stalled output freezes the whole pipeline; no
//  transaction is lost or repeated. Config writes are always taken.
// ----------------------------------------------------------------------------
module sphere_preview_pixel_shader_core
    import spps_pkg::*;
#(
    parameter int PREVIEW_SIZE = PREVIEW_SIZE_DEF
)(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [PIX_W-1:0] i_pixel_x,
    input  logic [PIX_W-1:0] i_pixel_y,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [CH_W-1:0]  o_red,
    output logic [CH_W-1:0]  o_green,
    output logic [CH_W-1:0]  o_blue,
    output logic             o_inside_sphere,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic        en;
    t_cfg        cfg;
    logic        g_vld, p_vld;
    t_side       g_side, p_side;
    logic [14:0] g_ndh;
    logic [15:0] p_pow;

    assign en          = !o_out_valid || i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;

    spps_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    spps_geom #(
        .PREVIEW_SIZE (PREVIEW_SIZE)
    ) u_geom (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_in_valid),
        .i_pixel_x (i_pixel_x),
        .i_pixel_y (i_pixel_y),
        .i_cfg     (cfg),
        .o_valid   (g_vld),
        .o_side    (g_side),
        .o_ndh     (g_ndh)
    );

    spps_pow u_pow (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (g_vld),
        .i_x     (g_ndh),
        .i_side  (g_side),
        .i_cfg   (cfg),
        .o_valid (p_vld),
        .o_pow   (p_pow),
        .o_side  (p_side)
    );

    spps_mix u_mix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (p_vld),
        .i_pow    (p_pow),
        .i_side   (p_side),
        .i_cfg    (cfg),
        .o_valid  (o_out_valid),
        .o_red    (o_red),
        .o_green  (o_green),
        .o_blue   (o_blue),
        .o_inside (o_inside_sphere)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sphere_preview_pixel_shader_core: drives pixel
// transactions under several register settings and idle/stall profiles,
// predicts each shaded pixel in fixed point and compares it in order.
// ----------------------------------------------------------------------------
import spps_pkg::*;

typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       on_disc;
} shade_t;

class pixel_shade_board;
    shade_t                awaited[$];
    int                    errors;
    int                    checked;
    int                    on_sphere;
    longint unsigned       alb_r, alb_g, alb_b, metal, rough, rot;

    function new();
        alb_r = 256; alb_g = 256; alb_b = 256;
        metal = 0; rough = 128; rot = 0;
    endfunction

    function void set_reg(t_cfg_idx idx, logic [8:0] val);
        case (idx)
            CFG_ALBEDO_RED:   alb_r = val;
            CFG_ALBEDO_GREEN: alb_g = val;
            CFG_ALBEDO_BLUE:  alb_b = val;
            CFG_METALLIC:     metal = val;
            CFG_ROUGHNESS:    rough = val;
            CFG_ROTATION:     rot   = val;
            default: ;
        endcase
    endfunction

    function longint coord_q14(longint p);
        longint          n;
        longint unsigned q;
        n = 2 * p - 95;
        q = ((n < 0 ? -n : n) * 16384 + 47) / 95;
        return n < 0 ? -longint'(q) : longint'(q);
    endfunction

    function longint unsigned root_floor(longint unsigned a);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 30;
        while (bitv > a) bitv >>= 2;
        while (bitv != 0) begin
            if (a >= res + bitv) begin
                a -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function longint unsigned round_q14(longint unsigned v30);
        longint unsigned r;
        r = (v30 + (64'd1 << 15)) >> 16;
        return r > 16384 ? 16384 : r;
    endfunction

    function void sincos_45(longint unsigned e, output longint s, output longint c);
        longint unsigned r, r2, t;
        r  = e * 64'd3373259426 / 180;
        r2 = (r * r) >> 30;
        t = (64'd1 << 30) - r2 / 42;
        t = (64'd1 << 30) - ((r2 * t) >> 30) / 20;
        t = (64'd1 << 30) - ((r2 * t) >> 30) / 6;
        s = round_q14((r * t) >> 30);
        t = (64'd1 << 30) - r2 / 56;
        t = (64'd1 << 30) - ((r2 * t) >> 30) / 30;
        t = (64'd1 << 30) - ((r2 * t) >> 30) / 12;
        t = (64'd1 << 30) - ((r2 * t) >> 30) / 2;
        c = round_q14(t);
    endfunction

    function void sincos_deg(longint unsigned deg, output longint s, output longint c);
        longint unsigned d, e;
        longint          a, b;
        d = deg % 360;
        e = d % 90;
        if (e <= 45) sincos_45(e, a, b);
        else sincos_45(90 - e, b, a);
        case (d / 90)
            0: begin s = a;  c = b;  end
            1: begin s = b;  c = -a; end
            2: begin s = -a; c = -b; end
            default: begin s = -b; c = a; end
        endcase
    endfunction

    function longint unsigned dot_clamp(longint nx, longint ny, longint nz,
                                        longint wx, longint wy, longint wz);
        longint          d;
        longint unsigned r;
        d = nx * wx + ny * wy + nz * wz;
        if (d <= 0) return 0;
        r = longint'(d) >>> 28;
        return r > 16384 ? 16384 : r;
    endfunction

    function longint unsigned spec_pow(longint unsigned x, longint unsigned p);
        longint unsigned m, mant, f, nl, t, k, g, h, acc;
        if (x == 0) return 0;
        m = 0;
        f = 0;
        while ((x >> (m + 1)) != 0) m++;
        mant = x << (15 - m);
        for (int i = 0; i < 16; i++) begin
            mant = (mant * mant) >> 15;
            f <<= 1;
            if (mant >= 65536) begin
                f |= 1;
                mant >>= 1;
            end
        end
        nl = (14 - m) * 65536 - f;
        t  = (nl * p) >> 8;
        k  = t >> 16;
        g  = t & 16'hFFFF;
        if (g == 0) begin
            acc = 131072;
        end else begin
            h = 65536 - g;
            acc = 65536;
            for (int i = 0; i < 8; i++)
                if ((h >> (15 - i)) & 1) acc = (acc * ROOT2_Q16[i]) >> 16;
            acc += (acc * (h & 255) * 45426) >> 32;
        end
        if (k + 3 >= 32) return 0;
        return acc >> (k + 3);
    endfunction

    function logic [7:0] chan(longint unsigned alb, longint unsigned dif,
                              longint unsigned sm);
        longint unsigned v;
        v = ((alb * dif + sm) * 255) >> 22;
        return v > 255 ? 8'd255 : v[7:0];
    endfunction

    function void note_pixel(logic [6:0] px, logic [6:0] py);
        shade_t          e;
        longint          u, v, len, z, s, c, nx, ny, nz, pq8;
        longint unsigned ndl, ndh, dif, sm;
        u = coord_q14(px);
        v = coord_q14(py);
        len = u * u + v * v;
        if (len > (longint'(1) << 28)) begin
            e.red = BG_RED; e.green = BG_GREEN; e.blue = BG_BLUE; e.on_disc = 1'b0;
        end else begin
            z = root_floor((longint'(1) << 28) - len);
            sincos_deg(rot, s, c);
            nx = u * c - z * s;
            ny = v * 16384;
            nz = u * s + z * c;
            ndl = dot_clamp(nx, ny, nz, 5771, 12366, 9068);
            ndh = dot_clamp(nx, ny, nz, 3274, 7015, 14440);
            dif = 4096 + ((3 * ndl) >> 2);
            pq8 = 26624 - 96 * longint'(rough);
            if (pq8 < 1024) pq8 = 1024;
            sm = spec_pow(ndh, pq8) * metal;
            e.red     = chan(alb_r, dif, sm);
            e.green   = chan(alb_g, dif, sm);
            e.blue    = chan(alb_b, dif, sm);
            e.on_disc = 1'b1;
            on_sphere++;
        end
        awaited.insert(awaited.size(), e);
    endfunction

    function void check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic ins);
        shade_t e;
        if (awaited.size() == 0) begin
            $error("pixel result with nothing awaited");
            errors++;
            return;
        end
        e = awaited.pop_front();
        checked++;
        if (r !== e.red) begin
            $error("red expected %0d got %0d", e.red, r); errors++;
        end
        if (g !== e.green) begin
            $error("green expected %0d got %0d", e.green, g); errors++;
        end
        if (b !== e.blue) begin
            $error("blue expected %0d got %0d", e.blue, b); errors++;
        end
        if (ins !== e.on_disc) begin
            $error("inside_sphere expected %0d got %0d", e.on_disc, ins); errors++;
        end
    endfunction
endclass

module tb_top;
    localparam longint CYCLE_LIMIT = 600000;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    logic [PIX_W-1:0] i_pixel_x = '0;
    logic [PIX_W-1:0] i_pixel_y = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic [CH_W-1:0]  o_red, o_green, o_blue;
    logic             o_inside_sphere;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    pixel_shade_board board = new();
    int               in_idle_pct = 0;
    int               out_stall_pct = 0;
    int               hold_left = 0;
    int               settings = 0;
    longint           cycles = 0;

    sphere_preview_pixel_shader_core dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) hold_left <= hold_left - 1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_pixel(o_red, o_green, o_blue, o_inside_sphere);
        if (!i_rst_n || hold_left > 0) i_out_ready <= 1'b0;
        else i_out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    task automatic send_pixel(logic [6:0] px, logic [6:0] py);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel_x  <= px;
        i_pixel_y  <= py;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_pixel(px, py);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [8:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(idx, val);
    endtask

    task automatic apply_settings(logic [8:0] ar, logic [8:0] ag, logic [8:0] ab,
                                  logic [8:0] me, logic [8:0] ro, logic [8:0] rt);
        i_in_valid <= 1'b0;
        while (board.awaited.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        write_reg(CFG_ALBEDO_RED, ar);
        write_reg(CFG_ALBEDO_GREEN, ag);
        write_reg(CFG_ALBEDO_BLUE, ab);
        write_reg(CFG_METALLIC, me);
        write_reg(CFG_ROUGHNESS, ro);
        write_reg(CFG_ROTATION, rt);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        settings++;
    endtask

    task automatic random_pixels(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 85)
                send_pixel(7'($urandom_range(95)), 7'($urandom_range(95)));
            else
                send_pixel(7'($urandom_range(127)), 7'($urandom_range(127)));
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: corners, center, edges, off-preview coordinates
        send_pixel(0, 0);     send_pixel(95, 95);  send_pixel(0, 95);
        send_pixel(95, 0);    send_pixel(47, 47);  send_pixel(48, 48);
        send_pixel(47, 0);    send_pixel(47, 95);  send_pixel(0, 47);
        send_pixel(95, 48);   send_pixel(127, 127); send_pixel(96, 50);
        send_pixel(50, 127);  send_pixel(60, 30);  send_pixel(30, 70);
        apply_settings(511, 256, 0, 256, 0, 359);
        send_pixel(47, 47); send_pixel(60, 30); send_pixel(66, 20); send_pixel(20, 70);
        apply_settings(0, 511, 128, 511, 511, 511);
        send_pixel(47, 47); send_pixel(60, 30); send_pixel(66, 20); send_pixel(90, 48);
        random_pixels(100);

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 66; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 66; end
                default: begin in_idle_pct = 23; out_stall_pct = 23; end
            endcase
            case (ph)
                0: apply_settings(256, 256, 256, 0, 128, 0);
                1: apply_settings(256, 0, 256, 256, 256, 90);
                2: apply_settings(200, 150, 100, 128, 64, 180);
                3: apply_settings(511, 511, 511, 511, 0, 270);
                default: apply_settings(9'($urandom_range(511)), 9'($urandom_range(511)),
                    9'($urandom_range(511)), 9'($urandom_range(511)),
                    9'($urandom_range(511)), 9'($urandom_range(511)));
            endcase
            if (ph == 4) begin
                in_idle_pct = 0;
                hold_left = 400;
            end
            random_pixels(215);
        end
        i_in_valid <= 1'b0;

        while (board.awaited.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("checked %0d shaded pixels (%0d on the sphere) over %0d register settings",
                 board.checked, board.on_sphere, settings);
        if (board.errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
src/spps_pkg.sv
src/spps_cfg.sv
src/spps_geom.sv
src/spps_pow.sv
src/spps_mix.sv
src/sphere_preview_pixel_shader_core.sv
tb/sv/tb_top.sv
